@@ src/nimc_pkg.sv @@
package nimc_pkg;

  // request codes
  localparam logic [3:0] REQ_REGISTER = 4'd0;
  localparam logic [3:0] REQ_SAVE     = 4'd1;
  localparam logic [3:0] REQ_RESTORE  = 4'd2;
  localparam logic [3:0] REQ_DISABLE  = 4'd3;
  localparam logic [3:0] REQ_ENABLE   = 4'd4;
  localparam logic [3:0] REQ_CHECK    = 4'd5;
  localparam logic [3:0] REQ_GSAVE    = 4'd6;
  localparam logic [3:0] REQ_GRESTORE = 4'd7;
  localparam logic [3:0] REQ_GRESET   = 4'd8;
  localparam logic [3:0] REQ_GHALF    = 4'd9;

  // mask actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MASK   = 2'd1;
  localparam logic [1:0] ACT_UNMASK = 2'd2;

  // register index
  localparam logic REG_REAL_LINE_MAP = 1'b0;

  typedef struct packed {
    logic [3:0] req_type;
    logic [5:0] line;
    logic       real_api;
    logic       in_real_isr;
    logic       in_async_isr;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic       line_enabled;
    logic [1:0] line_action;
    logic       global_enabled;
    logic [1:0] global_action;
    logic       schedule_enable;
  } rsp_t;

endpackage

@@ src/nested_interrupt_mask_counter.sv @@
// an accepted word is registered in stage 1, its result then in rsp_q (rsp_valid_o for 1 cycle)
// throughput: one word per cycle; busy stays low, the line counter ram is read on accept and
//   written back the next cycle, with forwarding when consecutive words hit the same line
// reset: asynchronous, active low; registration and enable bits clear, global counter goes to
//   one, schedule flag to zero, line map to zero; line counters are written on registration
// the receiver cannot stall: each result is shown for exactly one cycle
module nested_interrupt_mask_counter import nimc_pkg::*; #(
  parameter int NUM_LINES   = 64,
  parameter int COUNT_WIDTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam logic [COUNT_WIDTH-1:0] CntLimit = '1;
  localparam logic [COUNT_WIDTH-1:0] CntOne   = COUNT_WIDTH'(1);

  logic [63:0] real_map;
  logic        accept;

  // stage 1: request plus ram read data
  logic                   s1_valid_q;
  req_t                   s1_q;
  logic                   fwd_q;
  logic [COUNT_WIDTH-1:0] fwd_cnt_q;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic [NUM_LINES-1:0]   reg_q, reg_d;
  logic [NUM_LINES-1:0]   en_q, en_d;
  logic [COUNT_WIDTH-1:0] gcnt_q, gcnt_d;
  logic                   sched_q, sched_d;

  logic                   rsp_valid_q;
  rsp_t                   rsp_q, rsp_d;

  logic [AW-1:0]          idx;
  logic                   inrange, regd, is_real, allowed, lvalid;
  logic [COUNT_WIDTH-1:0] cur, lwdata, cnt_after, gdec;
  logic                   lwe, en_next;

  nimc_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .real_line_map_o (real_map)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  nimc_count_ram #(
    .Depth (NUM_LINES),
    .AddrW (AW),
    .DataW (COUNT_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (idx),
    .wdata_i (lwdata),
    .re_i    (accept),
    .raddr_i (req_i.line[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign idx     = s1_q.line[AW-1:0];
  assign inrange = ({1'b0, s1_q.line} < 7'(NUM_LINES));
  assign regd    = inrange && reg_q[idx];
  assign is_real = real_map[s1_q.line];
  assign allowed = s1_q.real_api ? is_real : (!is_real && !s1_q.in_real_isr);
  // ram read is one write behind when the previous word touched this line
  assign cur     = fwd_q ? fwd_cnt_q : ram_rdata;
  assign gdec    = (gcnt_q != '0) ? gcnt_q - CntOne : gcnt_q;

  always_comb begin
    reg_d   = reg_q;
    en_d    = en_q;
    gcnt_d  = gcnt_q;
    sched_d = sched_q;
    lwe     = 1'b0;
    lwdata  = cur;
    en_next = 1'b0;
    rsp_d   = '0;
    lvalid  = 1'b0;

    if (s1_valid_q) begin
      en_next = en_q[idx];
      unique case (s1_q.req_type)
        REQ_REGISTER: begin
          if (inrange) begin
            rsp_d.ok = 1'b1;
            if (!reg_q[idx]) begin
              reg_d[idx] = 1'b1;
              lwe        = 1'b1;
              lwdata     = CntOne;
            end
          end
        end
        REQ_CHECK: begin
          rsp_d.ok = regd;
        end
        REQ_SAVE, REQ_RESTORE, REQ_DISABLE, REQ_ENABLE: begin
          if (regd && allowed) begin
            rsp_d.ok = 1'b1;
            lwe      = 1'b1;
            unique case (s1_q.req_type)
              REQ_SAVE: begin
                lwdata              = (cur != CntLimit) ? cur + CntOne : cur;
                en_next             = 1'b0;
                rsp_d.line_action   = ACT_MASK;
              end
              REQ_RESTORE: begin
                lwdata = (cur != '0) ? cur - CntOne : cur;
                if (lwdata == '0) begin
                  en_next           = 1'b1;
                  rsp_d.line_action = ACT_UNMASK;
                end
              end
              REQ_DISABLE: begin
                lwdata              = CntOne;
                en_next             = 1'b0;
                rsp_d.line_action   = ACT_MASK;
              end
              default: begin
                lwdata              = '0;
                en_next             = 1'b1;
                rsp_d.line_action   = ACT_UNMASK;
              end
            endcase
            en_d[idx] = en_next;
          end
        end
        REQ_GSAVE: begin
          if (!s1_q.in_async_isr) begin
            rsp_d.ok            = 1'b1;
            rsp_d.global_action = ACT_MASK;
            gcnt_d              = (gcnt_q != CntLimit) ? gcnt_q + CntOne : gcnt_q;
            sched_d             = 1'b0;
          end
        end
        REQ_GRESTORE: begin
          if (!s1_q.in_async_isr) begin
            rsp_d.ok = 1'b1;
            gcnt_d   = gdec;
            if (gdec == '0) begin
              sched_d             = 1'b1;
              rsp_d.global_action = ACT_UNMASK;
            end else begin
              sched_d             = 1'b0;
              rsp_d.global_action = ACT_MASK;
            end
          end
        end
        REQ_GRESET: begin
          rsp_d.ok            = 1'b1;
          rsp_d.global_action = ACT_MASK;
          gcnt_d              = CntOne;
        end
        REQ_GHALF: begin
          rsp_d.ok = 1'b1;
          gcnt_d   = '0;
        end
        default: begin
        end
      endcase

      lvalid = (s1_q.req_type <= REQ_CHECK) && inrange &&
               (reg_q[idx] || (s1_q.req_type == REQ_REGISTER));
    end

    cnt_after             = lwe ? lwdata : cur;
    rsp_d.line_enabled    = lvalid && (cnt_after == '0);
    rsp_d.global_enabled  = (gcnt_d == '0);
    rsp_d.schedule_enable = sched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      reg_q       <= '0;
      en_q        <= '0;
      gcnt_q      <= CntOne;
      sched_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      fwd_q       <= lwe && (s1_q.line == req_i.line);
      reg_q       <= reg_d;
      en_q        <= en_d;
      gcnt_q      <= gcnt_d;
      sched_q     <= sched_d;
      rsp_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= req_i;
      fwd_cnt_q <= lwdata;
    end
    if (s1_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  // enable bit of a line tracks its counter being zero
  a_en_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && lwe |-> (en_next == (lwdata == '0)))
    else $error("line enable bit out of step with counter");

  a_action_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && ((rsp_o.line_action != ACT_NONE) || (rsp_o.global_action != ACT_NONE))
      |-> rsp_o.ok)
    else $error("mask action on refused word");

  a_unmask_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.global_action == ACT_UNMASK)
      |-> (rsp_o.schedule_enable && rsp_o.global_enabled))
    else $error("global unmask without schedule enable");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 rsp_valid_o)
    else $error("accepted word produced no result");
`endif

endmodule

@@ src/nimc_cfg_regs.sv @@
module nimc_cfg_regs import nimc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [63:0] real_line_map_o
);

  logic [63:0] map_q;
  logic        sel_map;

  // registers sit on 8-byte steps, bit 3 picks the index
  assign sel_map = (paddr[3] == REG_REAL_LINE_MAP);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_map) begin
      map_q <= pwdata;
    end
  end

  assign prdata          = sel_map ? map_q : '0;
  assign real_line_map_o = map_q;

endmodule

@@ src/nimc_count_ram.sv @@
module nimc_count_ram #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ bench/tb_nested_interrupt_mask_counter.sv @@
module tb_nested_interrupt_mask_counter;
  import nimc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LINES = 64;
  localparam int COUNT_W   = 8;
  localparam int REQ_BITS  = $bits(req_t);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [3:0] MAP_ADDR = 4'(REG_REAL_LINE_MAP) << 3;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic        busy;
  logic        rsp_valid_o;
  rsp_t        rsp_o;
  logic [63:0] prdata;
  logic        pready;

  nested_interrupt_mask_counter #(
    .NUM_LINES  (NUM_LINES),
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mirror of the block state
  logic [63:0]        real_lines;
  logic               line_known [NUM_LINES];
  logic [COUNT_W-1:0] line_depth [NUM_LINES];
  logic [COUNT_W-1:0] async_depth;
  logic               sched_ok;

  req_t       requests_to_send [$];
  rsp_t       mask_results_due [$];
  rsp_t       next_result;
  logic [5:0] hot_lines [8];
  logic       no_gaps = 1'b0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         maps_written = 0;

  initial begin
    real_lines  = '0;
    async_depth = COUNT_W'(1);
    sched_ok    = 1'b0;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_known[i] = 1'b0;
      line_depth[i] = '0;
    end
  end

  function automatic rsp_t update_mask_state(req_t r);
    rsp_t o;
    logic is_real;
    logic allowed;
    o = '0;
    if (r.req_type <= REQ_CHECK) begin
      if (r.req_type == REQ_REGISTER) begin
        if (!line_known[r.line]) begin
          line_known[r.line] = 1'b1;
          line_depth[r.line] = COUNT_W'(1);
        end
        o.ok = 1'b1;
      end else if (line_known[r.line]) begin
        is_real = real_lines[r.line];
        allowed = r.real_api ? is_real : (!is_real && !r.in_real_isr);
        if (r.req_type == REQ_CHECK) begin
          o.ok = 1'b1;
        end else if (allowed) begin
          o.ok = 1'b1;
          case (r.req_type)
            REQ_SAVE: begin
              if (line_depth[r.line] != COUNT_MAX) line_depth[r.line]++;
              o.line_action = ACT_MASK;
            end
            REQ_RESTORE: begin
              if (line_depth[r.line] != '0) line_depth[r.line]--;
              if (line_depth[r.line] == '0) o.line_action = ACT_UNMASK;
            end
            REQ_DISABLE: begin
              line_depth[r.line] = COUNT_W'(1);
              o.line_action = ACT_MASK;
            end
            default: begin
              line_depth[r.line] = '0;
              o.line_action = ACT_UNMASK;
            end
          endcase
        end
      end
      o.line_enabled = line_known[r.line] && (line_depth[r.line] == '0);
    end else begin
      case (r.req_type)
        REQ_GSAVE: begin
          if (!r.in_async_isr) begin
            o.ok = 1'b1;
            o.global_action = ACT_MASK;
            if (async_depth != COUNT_MAX) async_depth++;
            sched_ok = 1'b0;
          end
        end
        REQ_GRESTORE: begin
          if (!r.in_async_isr) begin
            o.ok = 1'b1;
            if (async_depth != '0) async_depth--;
            sched_ok = (async_depth == '0);
            o.global_action = sched_ok ? ACT_UNMASK : ACT_MASK;
          end
        end
        REQ_GRESET: begin
          o.ok = 1'b1;
          o.global_action = ACT_MASK;
          async_depth = COUNT_W'(1);
        end
        REQ_GHALF: begin
          o.ok = 1'b1;
          async_depth = '0;
        end
        default: ;
      endcase
    end
    o.global_enabled  = (async_depth == '0);
    o.schedule_enable = sched_ok;
    return o;
  endfunction

  function automatic req_t make_req(logic [3:0] op, logic [5:0] ln, logic api, logic rin,
                                    logic ain);
    req_t r;
    r.req_type     = op;
    r.line         = ln;
    r.real_api     = api;
    r.in_real_isr  = rin;
    r.in_async_isr = ain;
    return r;
  endfunction

  // mostly well-formed calls on a few hot lines, some pure noise
  function automatic req_t random_request();
    req_t r;
    int pick;
    logic [5:0] ln;
    r = req_t'(REQ_BITS'($urandom));
    if ($urandom_range(0, 99) < 12) return r;
    ln = hot_lines[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 10) r.req_type = REQ_REGISTER;
    else if (pick < 30) r.req_type = REQ_SAVE;
    else if (pick < 55) r.req_type = REQ_RESTORE;
    else if (pick < 62) r.req_type = REQ_DISABLE;
    else if (pick < 69) r.req_type = REQ_ENABLE;
    else if (pick < 77) r.req_type = REQ_CHECK;
    else if (pick < 86) r.req_type = REQ_GSAVE;
    else if (pick < 95) r.req_type = REQ_GRESTORE;
    else if (pick < 97) r.req_type = REQ_GRESET;
    else r.req_type = REQ_GHALF;
    r.line         = ln;
    r.real_api     = ($urandom_range(0, 9) == 0) ? !real_lines[ln] : real_lines[ln];
    r.in_real_isr  = r.real_api ? 1'($urandom) : ($urandom_range(0, 6) == 0);
    r.in_async_isr = ($urandom_range(0, 6) == 0);
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        mask_results_due.push_back(update_mask_state(req));
      end
      if (start && busy) begin
        // hold the word until it is taken
      end else if (requests_to_send.size() > 0 &&
                   (no_gaps || $urandom_range(0, 99) >= 28)) begin
        start <= 1'b1;
        req   <= requests_to_send.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (mask_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none actual %p", $time, rsp_o);
      end else begin
        next_result = mask_results_due.pop_front();
        check_field("ok", 2'(next_result.ok), 2'(rsp_o.ok));
        check_field("line_enabled", 2'(next_result.line_enabled), 2'(rsp_o.line_enabled));
        check_field("line_action", next_result.line_action, rsp_o.line_action);
        check_field("global_enabled", 2'(next_result.global_enabled),
                    2'(rsp_o.global_enabled));
        check_field("global_action", next_result.global_action, rsp_o.global_action);
        check_field("schedule_enable", 2'(next_result.schedule_enable),
                    2'(rsp_o.schedule_enable));
        results_seen++;
      end
    end
  end

  task automatic write_line_map(input logic [63:0] value);
    logic [63:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAP_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    real_lines = value;
    maps_written++;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      mismatches++;
      $display("%0t: real_line_map expected %h actual %h", $time, value, readback);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (requests_to_send.size() > 0 || start || mask_results_due.size() > 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_phase(input logic [63:0] map, input int count, input logic burst);
    write_line_map(map);
    foreach (hot_lines[i]) hot_lines[i] = 6'($urandom_range(0, NUM_LINES - 1));
    no_gaps = burst;
    repeat (count) requests_to_send.push_back(random_request());
    wait_drained();
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [5:0] deep_line;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // odd lines real, even lines async
    write_line_map(64'hAAAA_AAAA_AAAA_AAAA);
    requests_to_send.push_back(make_req(REQ_CHECK, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_SAVE, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_REGISTER, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_REGISTER, 6'd0, 1'b1, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(REQ_REGISTER, 6'd63, 1'b1, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_SAVE, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_SAVE, 6'd0, 1'b1, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_SAVE, 6'd0, 1'b0, 1'b1, 1'b0));
    repeat (3) requests_to_send.push_back(make_req(REQ_RESTORE, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_DISABLE, 6'd63, 1'b1, 1'b1, 1'b0));
    requests_to_send.push_back(make_req(REQ_SAVE, 6'd63, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_ENABLE, 6'd63, 1'b1, 1'b0, 1'b1));
    requests_to_send.push_back(make_req(REQ_CHECK, 6'd63, 1'b0, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(REQ_GSAVE, 6'd21, 1'b1, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(REQ_GSAVE, 6'd0, 1'b0, 1'b0, 1'b0));
    repeat (3) requests_to_send.push_back(make_req(REQ_GRESTORE, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_GRESET, 6'd63, 1'b1, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(REQ_GHALF, 6'd63, 1'b1, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(4'hF, 6'd63, 1'b1, 1'b1, 1'b1));
    requests_to_send.push_back(make_req(4'hA, 6'd0, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_REGISTER, 6'd42, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_ENABLE, 6'd42, 1'b0, 1'b0, 1'b1));
    wait_drained();

    random_phase(64'h0, 25, 1'b0);
    random_phase('1, 25, 1'b1);
    random_phase({$urandom, $urandom}, 25, 1'b0);

    // both nesting counters pushed into saturation and back
    write_line_map({$urandom, $urandom});
    foreach (hot_lines[i]) hot_lines[i] = 6'($urandom_range(0, NUM_LINES - 1));
    deep_line = hot_lines[0];
    requests_to_send.push_back(make_req(REQ_REGISTER, deep_line, 1'b0, 1'b0, 1'b0));
    requests_to_send.push_back(make_req(REQ_DISABLE, deep_line, real_lines[deep_line],
                                        1'b0, 1'b0));
    repeat (255) begin
      requests_to_send.push_back(make_req(REQ_SAVE, deep_line, real_lines[deep_line],
                                          1'b0, 1'b0));
    end
    repeat (2) begin
      requests_to_send.push_back(make_req(REQ_RESTORE, deep_line, real_lines[deep_line],
                                          1'b0, 1'b0));
    end
    requests_to_send.push_back(make_req(REQ_GRESET, 6'd0, 1'b0, 1'b0, 1'b0));
    repeat (255) requests_to_send.push_back(make_req(REQ_GSAVE, 6'd0, 1'b0, 1'b0, 1'b0));
    repeat (2) requests_to_send.push_back(make_req(REQ_GRESTORE, 6'd0, 1'b0, 1'b0, 1'b0));
    wait_drained();

    $display("checked %0d results over %0d line-map settings, with directed refusals,",
             results_seen, maps_written);
    $display("saturated line and global nesting, and random calls with idle gaps");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results still due", mask_results_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
